/* hw/rtl/sltr_pkg.sv */
package sltr_pkg;

  localparam int unsigned RawW = 28;
  localparam logic [31:0] LcgMult = 32'd69069;

  typedef logic [14:0] perturb_t;

  localparam perturb_t PERTURB [256] = '{
    15'd28985, 15'd27138, 15'd26457, 15'd9451, 15'd17764, 15'd10909, 15'd28790, 15'd8716,
    15'd6361, 15'd4853, 15'd17798, 15'd21977, 15'd19643, 15'd20662, 15'd10834, 15'd20103,
    15'd27067, 15'd28634, 15'd18623, 15'd25849, 15'd8576, 15'd26234, 15'd23887, 15'd18228,
    15'd32587, 15'd4836, 15'd3306, 15'd1811, 15'd3035, 15'd24559, 15'd18399, 15'd315,
    15'd26766, 15'd907, 15'd24102, 15'd12370, 15'd9674, 15'd2972, 15'd10472, 15'd16492,
    15'd22683, 15'd11529, 15'd27968, 15'd30406, 15'd13213, 15'd2319, 15'd23620, 15'd16823,
    15'd10013, 15'd23772, 15'd21567, 15'd1251, 15'd19579, 15'd20313, 15'd18241, 15'd30130,
    15'd8402, 15'd20807, 15'd27354, 15'd7169, 15'd21211, 15'd17293, 15'd5410, 15'd19223,
    15'd10255, 15'd22480, 15'd27388, 15'd9946, 15'd15628, 15'd24389, 15'd17308, 15'd2370,
    15'd9530, 15'd31683, 15'd25927, 15'd23567, 15'd11694, 15'd26397, 15'd32602, 15'd15031,
    15'd18255, 15'd17582, 15'd1422, 15'd28835, 15'd23607, 15'd12597, 15'd20602, 15'd10138,
    15'd5212, 15'd1252, 15'd10074, 15'd23166, 15'd19823, 15'd31667, 15'd5902, 15'd24630,
    15'd18948, 15'd14330, 15'd14950, 15'd8939, 15'd23540, 15'd21311, 15'd22428, 15'd22391,
    15'd3583, 15'd29004, 15'd30498, 15'd18714, 15'd4278, 15'd2437, 15'd22430, 15'd3439,
    15'd28313, 15'd23161, 15'd25396, 15'd13471, 15'd19324, 15'd15287, 15'd2563, 15'd18901,
    15'd13103, 15'd16867, 15'd9714, 15'd14322, 15'd15197, 15'd26889, 15'd19372, 15'd26241,
    15'd31925, 15'd14640, 15'd11497, 15'd8941, 15'd10056, 15'd6451, 15'd28656, 15'd10737,
    15'd13874, 15'd17356, 15'd8281, 15'd25937, 15'd1661, 15'd4850, 15'd7448, 15'd12744,
    15'd21826, 15'd5477, 15'd10167, 15'd16705, 15'd26897, 15'd8839, 15'd30947, 15'd27978,
    15'd27283, 15'd24685, 15'd32298, 15'd3525, 15'd12398, 15'd28726, 15'd9475, 15'd10208,
    15'd617, 15'd13467, 15'd22287, 15'd2376, 15'd6097, 15'd26312, 15'd2974, 15'd9114,
    15'd21787, 15'd28010, 15'd4725, 15'd15387, 15'd3274, 15'd10762, 15'd31695, 15'd17320,
    15'd18324, 15'd12441, 15'd16801, 15'd27376, 15'd22464, 15'd7500, 15'd5666, 15'd18144,
    15'd15314, 15'd31914, 15'd31627, 15'd6495, 15'd5226, 15'd31203, 15'd2331, 15'd4668,
    15'd12650, 15'd18275, 15'd351, 15'd7268, 15'd31319, 15'd30119, 15'd7600, 15'd2905,
    15'd13826, 15'd11343, 15'd13053, 15'd15583, 15'd30055, 15'd31093, 15'd5067, 15'd761,
    15'd9685, 15'd11070, 15'd21369, 15'd27155, 15'd3663, 15'd26542, 15'd20169, 15'd12161,
    15'd15411, 15'd30401, 15'd7580, 15'd31784, 15'd8985, 15'd29367, 15'd20989, 15'd14203,
    15'd29694, 15'd21167, 15'd10337, 15'd1706, 15'd28578, 15'd887, 15'd3373, 15'd19477,
    15'd14382, 15'd675, 15'd7033, 15'd15111, 15'd26138, 15'd12252, 15'd30996, 15'd21409,
    15'd25678, 15'd18555, 15'd13256, 15'd23316, 15'd22407, 15'd16727, 15'd991, 15'd9236,
    15'd5373, 15'd29402, 15'd6117, 15'd15241, 15'd27715, 15'd19291, 15'd19888, 15'd19847
  };

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

/* hw/rtl/sltr_mod.sv */
module sltr_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sltr_pkg::pipe_ctl_t         ctl,
  input  logic [sltr_pkg::RawW-1:0]   raw,
  input  logic [32:0]                 divisor,
  input  logic [31:0]                 low,
  output logic                        rem_valid,
  output logic [31:0]                 rem,
  output logic [31:0]                 rem_low
);
  localparam int N = sltr_pkg::RawW;

  logic                v_r   [N];
  logic [31:0]         rem_r [N];
  logic [N-1:0]        dnd_r [N];
  logic [32:0]         dvs_r [N];
  logic [31:0]         lo_r  [N];

  function automatic logic [31:0] step(input logic [31:0] r, input logic b,
                                       input logic [32:0] d);
    logic [32:0] s;
    s = {r, b};
    if (s >= d) begin
      s = s - d;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (ctl.en) begin
      v_r[0] <= ctl.valid;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= step(32'd0, raw[N-1], divisor);
      dnd_r[0] <= {raw[N-2:0], 1'b0};
      dvs_r[0] <= divisor;
      lo_r[0]  <= low;
      for (int k = 1; k < N; k++) begin
        rem_r[k] <= step(rem_r[k-1], dnd_r[k-1][N-1], dvs_r[k-1]);
        dnd_r[k] <= {dnd_r[k-1][N-2:0], 1'b0};
        dvs_r[k] <= dvs_r[k-1];
        lo_r[k]  <= lo_r[k-1];
      end
    end
  end

  assign rem_valid = v_r[N-1];
  assign rem       = rem_r[N-1];
  assign rem_low   = lo_r[N-1];
endmodule

/* hw/rtl/seeded_table_lcg_random_range.sv */
// Pipeline: 3 generator stages, 28 remainder stages and one output stage.
// Throughput: one request per cycle while the output is not stalled.
// The pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module seeded_table_lcg_random_range (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_seed_value,
  input  logic signed [31:0] in_range_low,
  input  logic signed [31:0] in_range_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_random_value
);
  logic en;
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  sltr_pkg::perturb_t s1_t_r;
  logic [32:0] s1_dvs_r, s2_dvs_r, s3_dvs_r;
  logic [31:0] s1_lo_r, s2_lo_r, s3_lo_r;
  logic [31:0] s2_st_r;
  logic [sltr_pkg::RawW-1:0] s3_raw_r;
  logic [31:0] idx_sum, span, st_nxt;
  logic [31:0] out_r;
  logic div_v;
  logic [31:0] div_rem, div_lo;
  sltr_pkg::pipe_ctl_t ctl;

  assign en       = !out_v_r || out_ready;
  assign in_ready = en;
  assign idx_sum  = in_seed_value + in_range_low + in_range_high;
  assign span     = in_range_high - in_range_low + 32'd1;
  assign st_nxt   = s2_st_r + {17'd0, sltr_pkg::PERTURB[s2_st_r[7:0]]} + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r   <= sltr_pkg::PERTURB[idx_sum[7:0]];
      s1_dvs_r <= {(span == 32'd0), span};
      s1_lo_r  <= in_range_low;
      s2_st_r  <= {17'd0, s1_t_r} * sltr_pkg::LcgMult;
      s2_dvs_r <= s1_dvs_r;
      s2_lo_r  <= s1_lo_r;
      s3_raw_r <= st_nxt[sltr_pkg::RawW-1:0];
      s3_dvs_r <= s2_dvs_r;
      s3_lo_r  <= s2_lo_r;
      out_r    <= div_lo + div_rem;
    end
  end

  assign ctl.en    = en;
  assign ctl.valid = s3_v_r;

  sltr_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .raw       (s3_raw_r),
    .divisor   (s3_dvs_r),
    .low       (s3_lo_r),
    .rem_valid (div_v),
    .rem       (div_rem),
    .rem_low   (div_lo)
  );

  assign out_valid        = out_v_r;
  assign out_random_value = out_r;
endmodule

/* hw/rtl/sltr_checker.sv */
module sltr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_random_value
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready while output empty");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("accepted request during output stall");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_random_value)))
    else $error("stalled result changed");
endmodule

bind seeded_table_lcg_random_range sltr_checker u_sltr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_random_value (out_random_value)
);

/* tb/sv/range_rng_checker.sv */
module range_rng_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_seed_value,
  input  logic signed [31:0] in_range_low,
  input  logic signed [31:0] in_range_high,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_random_value,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] expected_values[$];

  function automatic logic signed [31:0] predict_range_value(
    logic [31:0] seed, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] gen;
    logic [31:0] mixed;
    logic [31:0] raw;
    logic [31:0] span;
    logic [31:0] offset;
    mixed = seed + lo + hi;
    gen = {17'd0, sltr_pkg::PERTURB[mixed[7:0]]};
    gen = gen * sltr_pkg::LcgMult;
    gen = gen + {17'd0, sltr_pkg::PERTURB[gen[7:0]]} + 32'd1;
    raw = gen & 32'h0fffffff;
    span = hi - lo + 32'd1;
    if (span == 32'd1) begin
      return lo;
    end
    offset = (span == 32'd0) ? raw : (raw % span);
    return lo + offset;
  endfunction

  assign pending_count = expected_values.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_values.push_back(
          predict_range_value(in_seed_value, in_range_low, in_range_high));
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) begin
            $display("unexpected result %0d", out_random_value);
          end
        end else begin
          want = expected_values.pop_front();
          if (want !== out_random_value) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch: expected %0d got %0d", want, out_random_value);
            end
          end
        end
      end
    end
  end
endmodule

/* tb/sv/tb_seeded_table_lcg_random_range.sv */
module tb_seeded_table_lcg_random_range;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1500;
  localparam int CycleLimit = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_seed_value = '0;
  logic signed [31:0] in_range_low = '0;
  logic signed [31:0] in_range_high = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_random_value;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;

  always #6 clk = ~clk;

  seeded_table_lcg_random_range uut (.*);

  range_rng_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
      out_ready <= 1'b0;
      repeat (gap) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_request(logic [31:0] seed, logic [31:0] lo, logic [31:0] hi,
                              int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seed_value <= seed;
    in_range_low <= lo;
    in_range_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h80000000 + $urandom_range(3);
      1: return 32'h7fffffff - $urandom_range(3);
      2: return $urandom_range(7) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    int gap;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_request(32'h0, 32'h0, 32'h0, 0);
    send_request(32'hffffffff, 32'h80000000, 32'h7fffffff, 0);
    send_request(32'h12345678, 32'h80000000, 32'h7fffffff, 0);
    send_request(32'h0, 32'h7fffffff, 32'h7fffffff, 0);
    send_request(32'h5, 32'h80000000, 32'h80000000, 0);
    send_request(32'h9, 32'h10, 32'h11, 0);
    send_request(32'hffffffff, 32'h7fffffff, 32'h80000000, 1);
    send_request(32'haaaaaaaa, 32'h00000064, 32'hfffffff6, 0);
    send_request(32'h55555555, 32'hffffffff, 32'h00000001, 2);
    send_request(32'h1, 32'h0, 32'h0fffffff, 0);
    send_request(32'h2, 32'h0, 32'h10000000, 0);
    send_request(32'h3, 32'h80000001, 32'h7fffffff, 0);
    send_request(32'h4, 32'h80000000, 32'h7ffffffe, 0);
    for (int i = 0; i < NumRandom; i++) begin
      lo = pick_value();
      case ($urandom_range(4))
        0: hi = lo;
        1: hi = lo + $urandom_range(1000);
        2: hi = lo + $urandom_range(1, 4);
        default: hi = pick_value();
      endcase
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
      send_request($urandom, lo, hi, gap);
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/sltr_pkg.sv
hw/rtl/sltr_mod.sv
hw/rtl/seeded_table_lcg_random_range.sv
hw/rtl/sltr_checker.sv
tb/sv/range_rng_checker.sv
tb/sv/tb_seeded_table_lcg_random_range.sv
